### rtl/imb_pkg.sv
package imb_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int TIMER_WIDTH  = 20;
    localparam int CFG_WIDTH    = 20;
    localparam int IDX_WIDTH    = 3;

    // register indexes
    localparam logic [IDX_WIDTH-1:0] REG_BIAS_X  = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_BIAS_Y  = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_BIAS_Z  = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_STILL   = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_SETTLE  = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_G_SOFT  = 3'd5;
    localparam logic [IDX_WIDTH-1:0] REG_G_DYN   = 3'd6;
    localparam logic [IDX_WIDTH-1:0] REG_G_SETL  = 3'd7;

    // divider geometry: quotient fits 17 bits for both uses
    localparam int DIV_NW = 57;
    localparam int DIV_DW = 41;
    localparam int DIV_QW = 17;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [TIMER_WIDTH-1:0] timer_t;

    typedef struct packed {
        logic update;
        logic seed;
    } lane_ctrl_t;

    typedef struct packed {
        logic [17:0] elapsed_us;
        sample_t     accel_x;
        sample_t     accel_y;
        sample_t     accel_z;
        sample_t     gyro_x;
        sample_t     gyro_y;
        sample_t     gyro_z;
    } in_item_t;

    typedef struct packed {
        sample_t     filt_accel_x;
        sample_t     filt_accel_y;
        sample_t     filt_accel_z;
        sample_t     filt_gyro_x;
        sample_t     filt_gyro_y;
        sample_t     filt_gyro_z;
        logic [15:0] fusion_gain;
        logic        still_det;
        logic        settle_win;
        logic [13:0] target_rate_hz;
        logic [17:0] next_period_us;
    } out_item_t;

endpackage

### rtl/imb_in_if.sv
interface imb_in_if;
    import imb_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/imb_out_if.sv
interface imb_out_if;
    import imb_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/imu_motion_beta_scheduler.sv
// channel   dir   handshake      payload
// in_ch     in    valid/ready    elapsed time, accel xyz, gyro xyz
// out_ch    out   valid/ready    filtered axes, gain, flags, rate, period
// cfg       in    cfg_we         cfg_index selects register, cfg_data value
//
// each item passes twice through the shared divider (coefficient, then period)
// and twice through the shared square root (accel norm, then gyro norm), with
// sequencing states between. six filter lanes update in parallel, all in the
// same cycle; a new item is accepted only in the idle state, once the last
// one has left the output state. a result still waiting in the output register
// holds the next item in the last state until it is taken.
// reset is asynchronous, active low; no clearing pass is needed.
module imu_motion_beta_scheduler (
    input  logic                           clk,
    input  logic                           rst_n,
    imb_in_if.sink                         in_ch,
    imb_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [imb_pkg::IDX_WIDTH-1:0]  cfg_index,
    input  logic [imb_pkg::CFG_WIDTH-1:0]  cfg_data
);
    import imb_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_COEF0 = 4'd1;
    localparam logic [3:0] S_COEF1 = 4'd2;
    localparam logic [3:0] S_COEFW = 4'd3;
    localparam logic [3:0] S_FILT  = 4'd4;
    localparam logic [3:0] S_SQ    = 4'd5;
    localparam logic [3:0] S_SUM   = 4'd6;
    localparam logic [3:0] S_SQRA  = 4'd7;
    localparam logic [3:0] S_SQRG  = 4'd8;
    localparam logic [3:0] S_ERR   = 4'd9;
    localparam logic [3:0] S_MET   = 4'd10;
    localparam logic [3:0] S_DES   = 4'd11;
    localparam logic [3:0] S_RATE  = 4'd12;
    localparam logic [3:0] S_PERW  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    localparam logic [22:0] LPF_W       = 23'd4941298;
    localparam logic [40:0] LPF_DEN0    = 41'd65536000000;
    localparam logic [13:0] RATE_MIN    = 14'd6400;
    localparam logic [13:0] RATE_MAX    = 14'd15360;
    localparam logic [13:0] RATE_RESET  = 14'd7680;
    localparam logic [13:0] RATE_SPAN   = 14'd8960;
    localparam logic [14:0] SMOOTH_Q16  = 15'd11796;
    localparam logic [56:0] PERIOD_NUM  = 57'd256000000;
    localparam logic [17:0] PERIOD_MIN  = 18'd2000;
    localparam logic [17:0] PERIOD_MAX  = 18'd200000;
    localparam logic [17:0] DT_MIN      = 18'd500;
    localparam logic [17:0] DT_MAX      = 18'd200000;
    localparam logic [15:0] ACCEL_ONE   = 16'd4096;
    localparam logic [16:0] ERR_STILL   = 17'd204;
    localparam logic [15:0] GYRO_STILL  = 16'd81;
    localparam logic [15:0] GYRO_ROT    = 16'd359;
    localparam logic [16:0] ERR_SOFT    = 17'd615;
    localparam logic [16:0] ERR_HARD    = 17'd1025;
    localparam logic [16:0] METRIC_ONE  = 17'd65536;
    localparam timer_t      TIMER_MAX   = {TIMER_WIDTH{1'b1}};

    // floor(160 v / 3) capped at 1.0 Q1.16
    function automatic logic [16:0] metric_part(input logic [16:0] v);
        logic [17:0] n;
        logic [38:0] p;
        begin
            n = 18'({v, 7'b0}) + 18'({v, 5'b0});
            p = n * 21'd699051;
            if (v >= 17'd1229)
            begin
                metric_part = METRIC_ONE;
            end
            else
            begin
                metric_part = 17'(p[38:21]);
            end
        end
    endfunction

    function automatic timer_t timer_add(input timer_t t, input logic [17:0] d);
        logic [TIMER_WIDTH:0] s;
        begin
            s = {1'b0, t} + (TIMER_WIDTH+1)'(d);
            timer_add = s[TIMER_WIDTH] ? TIMER_MAX : s[TIMER_WIDTH-1:0];
        end
    endfunction

    // configuration registers
    sample_t     bias_reg [3];
    timer_t      still_hold_reg;
    timer_t      settle_time_reg;
    logic [15:0] gain_soft_reg;
    logic [15:0] gain_dyn_reg;
    logic [15:0] gain_settle_reg;

    // control and state
    logic [3:0]  state_reg, state_next;
    logic        seeded_reg;
    timer_t      still_el_reg;
    logic        rot_reg;
    timer_t      settle_el_reg;
    logic [13:0] rate_reg;
    logic        out_valid_reg;

    // per-item working registers
    logic [17:0] dt_reg;
    sample_t     smp_reg [6];
    logic [40:0] x_reg;
    logic [16:0] coef_reg;
    logic [31:0] sum_g_reg;
    logic [15:0] amag_reg, gnorm_reg;
    logic [16:0] err_reg;
    logic        still_det_reg;
    logic [16:0] mg_reg, ma_reg;
    logic [13:0] desired_reg;
    logic [15:0] gain_reg;
    out_item_t   out_data_reg;

    // lanes and shared units
    lane_ctrl_t        lane_ctrl;
    sample_t           filt [6];
    logic [31:0]       sq [6];
    logic              div_start, div_busy, div_done;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic [DIV_QW-1:0] div_quot;
    logic              sqrt_start, sqrt_busy, sqrt_done;
    logic [31:0]       sqrt_rad;
    logic [15:0]       sqrt_root;

    logic              in_fire;
    logic [17:0]       dt_in;
    logic [40:0]       den_c;
    logic [56:0]       num_c;
    logic [16:0]       amag_diff;
    logic              still_cond;
    timer_t            still_new;
    logic              rot_new;
    timer_t            settle_new;
    timer_t            settle_sum;
    logic [16:0]       metric;
    logic [30:0]       des_prod;
    logic signed [14:0] rdiff;
    logic signed [30:0] rprod;
    logic [30:0]       rmag;
    logic signed [17:0] rstep;
    logic signed [17:0] rnew;
    logic [13:0]       rate_clamped;
    logic [17:0]       period_c;
    logic signed [16:0] gyro_diff [3];

    assign in_fire     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);

    // elapsed time clamp and gyro bias subtraction
    always_comb
    begin
        dt_in = in_ch.data.elapsed_us;
        if (dt_in < DT_MIN)
        begin
            dt_in = DT_MIN;
        end
        else if (dt_in > DT_MAX)
        begin
            dt_in = DT_MAX;
        end
        gyro_diff[0] = 17'(in_ch.data.gyro_x) - 17'(bias_reg[0]);
        gyro_diff[1] = 17'(in_ch.data.gyro_y) - 17'(bias_reg[1]);
        gyro_diff[2] = 17'(in_ch.data.gyro_z) - 17'(bias_reg[2]);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg[0]     <= '0;
            bias_reg[1]     <= '0;
            bias_reg[2]     <= '0;
            still_hold_reg  <= 20'd350000;
            settle_time_reg <= 20'd600000;
            gain_soft_reg   <= 16'd1311;
            gain_dyn_reg    <= 16'd3932;
            gain_settle_reg <= 16'd19661;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BIAS_X: bias_reg[0]     <= cfg_data[15:0];
                REG_BIAS_Y: bias_reg[1]     <= cfg_data[15:0];
                REG_BIAS_Z: bias_reg[2]     <= cfg_data[15:0];
                REG_STILL:  still_hold_reg  <= cfg_data[TIMER_WIDTH-1:0];
                REG_SETTLE: settle_time_reg <= cfg_data[TIMER_WIDTH-1:0];
                REG_G_SOFT: gain_soft_reg   <= cfg_data[15:0];
                REG_G_DYN:  gain_dyn_reg    <= cfg_data[15:0];
                REG_G_SETL: gain_settle_reg <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    // filter lanes, one per axis
    assign lane_ctrl.update = (state_reg == S_FILT) && seeded_reg;
    assign lane_ctrl.seed   = (state_reg == S_FILT) && !seeded_reg;

    for (genvar i = 0; i < 6; i++)
    begin : g_lane
        imb_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (lane_ctrl),
            .sample (smp_reg[i]),
            .coef   (coef_reg),
            .filt   (filt[i]),
            .sq     (sq[i])
        );
    end

    // shared divider: filter coefficient, then period
    always_comb
    begin
        den_c     = LPF_DEN0 + x_reg;
        num_c     = {x_reg, 16'b0} + 57'(den_c[40:1]);
        div_start = (state_reg == S_COEF1) || (state_reg == S_RATE);
        if (state_reg == S_RATE)
        begin
            div_num = PERIOD_NUM;
            div_den = 41'(rate_clamped);
        end
        else
        begin
            div_num = num_c;
            div_den = den_c;
        end
    end

    imb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // shared square root: accel norm, then gyro norm
    assign sqrt_start = (state_reg == S_SUM) || (state_reg == S_SQRA && sqrt_done);
    assign sqrt_rad   = (state_reg == S_SUM) ? sq[0] + sq[1] + sq[2] : sum_g_reg;

    imb_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (sqrt_rad),
        .busy  (sqrt_busy),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // timers, metric and rate arithmetic
    always_comb
    begin
        amag_diff  = 17'(amag_reg) - 17'(ACCEL_ONE);
        still_cond = (err_reg <= ERR_STILL) && (gnorm_reg <= GYRO_STILL);
        still_new  = still_cond ? timer_add(still_el_reg, dt_reg) : '0;
        settle_sum = timer_add(settle_el_reg, dt_reg);
        rot_new    = rot_reg;
        settle_new = settle_el_reg;
        if (gnorm_reg >= GYRO_ROT)
        begin
            rot_new    = 1'b1;
            settle_new = '0;
        end
        else if (rot_reg)
        begin
            settle_new = settle_sum;
            if (settle_sum >= settle_time_reg)
            begin
                rot_new    = 1'b0;
                settle_new = '0;
            end
        end

        metric   = (mg_reg > ma_reg) ? mg_reg : ma_reg;
        des_prod = 31'(RATE_SPAN) * 31'(metric) + 31'd32768;

        rdiff = 15'(desired_reg) - 15'(rate_reg);
        rprod = $signed({1'b0, SMOOTH_Q16}) * 31'(rdiff);
        rmag  = rprod[30] ? 31'(-rprod) : 31'(rprod);
        rmag  = rmag + 31'd32768;
        rstep = rprod[30] ? -$signed({3'b0, rmag[30:16]}) : $signed({3'b0, rmag[30:16]});
        rnew  = rstep + 18'(rate_reg);
        if (rnew < $signed(18'(RATE_MIN)))
        begin
            rate_clamped = RATE_MIN;
        end
        else if (rnew > $signed(18'(RATE_MAX)))
        begin
            rate_clamped = RATE_MAX;
        end
        else
        begin
            rate_clamped = rnew[13:0];
        end

        period_c = 18'(div_quot);
        if (div_quot < 17'(PERIOD_MIN))
        begin
            period_c = PERIOD_MIN;
        end
        else if (div_quot > 17'(PERIOD_MAX))
        begin
            period_c = PERIOD_MAX;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_COEF0;
            S_COEF0: state_next = S_COEF1;
            S_COEF1: state_next = S_COEFW;
            S_COEFW: if (div_done) state_next = S_FILT;
            S_FILT:  state_next = S_SQ;
            S_SQ:    state_next = S_SUM;
            S_SUM:   state_next = S_SQRA;
            S_SQRA:  if (sqrt_done) state_next = S_SQRG;
            S_SQRG:  if (sqrt_done) state_next = S_ERR;
            S_ERR:   state_next = S_MET;
            S_MET:   state_next = S_DES;
            S_DES:   state_next = S_RATE;
            S_RATE:  state_next = S_PERW;
            S_PERW:  if (div_done) state_next = S_OUT;
            S_OUT:   if (!out_valid_reg || out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            seeded_reg     <= 1'b0;
            still_el_reg   <= '0;
            rot_reg        <= 1'b0;
            settle_el_reg  <= '0;
            rate_reg       <= RATE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FILT)
            begin
                seeded_reg <= 1'b1;
            end
            if (state_reg == S_MET)
            begin
                still_el_reg  <= still_new;
                rot_reg       <= rot_new;
                settle_el_reg <= settle_new;
            end
            if (state_reg == S_RATE)
            begin
                rate_reg <= rate_clamped;
            end
            if (state_reg == S_OUT && (!out_valid_reg || out_ch.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // per-item payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dt_reg     <= dt_in;
            smp_reg[0] <= in_ch.data.accel_x;
            smp_reg[1] <= in_ch.data.accel_y;
            smp_reg[2] <= in_ch.data.accel_z;
            for (int k = 0; k < 3; k++)
            begin
                if (gyro_diff[k] > 17'sd32767)
                begin
                    smp_reg[3+k] <= 16'sh7fff;
                end
                else if (gyro_diff[k] < -17'sd32768)
                begin
                    smp_reg[3+k] <= 16'sh8000;
                end
                else
                begin
                    smp_reg[3+k] <= gyro_diff[k][15:0];
                end
            end
        end
        if (state_reg == S_COEF0)
        begin
            x_reg <= 41'(LPF_W) * 41'(dt_reg);
        end
        if (state_reg == S_COEFW && div_done)
        begin
            coef_reg <= div_quot;
        end
        if (state_reg == S_SUM)
        begin
            sum_g_reg <= sq[3] + sq[4] + sq[5];
        end
        if (state_reg == S_SQRA && sqrt_done)
        begin
            amag_reg <= sqrt_root;
        end
        if (state_reg == S_SQRG && sqrt_done)
        begin
            gnorm_reg <= sqrt_root;
        end
        if (state_reg == S_ERR)
        begin
            err_reg <= amag_diff[16] ? 17'(-amag_diff) : amag_diff;
        end
        if (state_reg == S_MET)
        begin
            still_det_reg <= still_new >= still_hold_reg;
            mg_reg        <= metric_part(17'(gnorm_reg));
            ma_reg        <= metric_part(err_reg);
        end
        if (state_reg == S_DES)
        begin
            desired_reg <= RATE_MIN + 14'(des_prod[30:16]);
            if (err_reg >= ERR_HARD)
            begin
                gain_reg <= '0;
            end
            else if (err_reg >= ERR_SOFT)
            begin
                gain_reg <= gain_soft_reg;
            end
            else if (still_det_reg || rot_reg)
            begin
                gain_reg <= gain_settle_reg;
            end
            else
            begin
                gain_reg <= gain_dyn_reg;
            end
        end
        if (state_reg == S_OUT && (!out_valid_reg || out_ch.ready))
        begin
            out_data_reg.filt_accel_x   <= filt[0];
            out_data_reg.filt_accel_y   <= filt[1];
            out_data_reg.filt_accel_z   <= filt[2];
            out_data_reg.filt_gyro_x    <= filt[3];
            out_data_reg.filt_gyro_y    <= filt[4];
            out_data_reg.filt_gyro_z    <= filt[5];
            out_data_reg.fusion_gain    <= gain_reg;
            out_data_reg.still_det      <= still_det_reg;
            out_data_reg.settle_win     <= rot_reg;
            out_data_reg.target_rate_hz <= rate_reg;
            out_data_reg.next_period_us <= period_c;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // checks
    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        rate_reg >= RATE_MIN && rate_reg <= RATE_MAX)
        else $error("smoothed rate out of range");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_COEF0)
        else $error("accepted item did not start");

    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !div_busy && !sqrt_busy)
        else $error("arithmetic unit busy while idle");

    a_settle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !rot_reg |-> settle_el_reg == '0)
        else $error("settle timer running without rotation");
endmodule

### rtl/imb_lane.sv
module imb_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  imb_pkg::lane_ctrl_t ctrl,
    input  imb_pkg::sample_t    sample,
    input  logic [16:0]         coef,
    output imb_pkg::sample_t    filt,
    output logic [31:0]         sq
);
    import imb_pkg::*;

    sample_t            y_reg;
    sample_t            y_next;
    logic [31:0]        sq_reg;
    logic signed [16:0] diff;
    logic signed [34:0] prod;
    logic [34:0]        mag;
    logic [34:0]        mag_rnd;
    logic signed [19:0] step;
    logic signed [19:0] y_sum;
    logic signed [31:0] y_sq;

    // y += coef * (s - y) / 2^16, rounded half away from zero; a seed loads y = s
    always_comb
    begin
        diff    = 17'(sample) - 17'(y_reg);
        prod    = $signed({1'b0, coef}) * diff;
        mag     = prod[34] ? 35'(-prod) : 35'(prod);
        mag_rnd = mag + 35'd32768;
        step    = prod[34] ? -$signed({1'b0, mag_rnd[34:16]})
                           : $signed({1'b0, mag_rnd[34:16]});
        y_sum   = step + 20'(y_reg);
        y_next  = y_reg;
        if (ctrl.seed)
        begin
            y_next = sample;
        end
        else if (ctrl.update)
        begin
            y_next = y_sum[SAMPLE_WIDTH-1:0];
        end
        y_sq = y_reg * y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_reg <= '0;
        end
        else
        begin
            y_reg <= y_next;
        end
    end

    // square for the norm, registered from the filter state
    always_ff @(posedge clk)
    begin
        sq_reg <= 32'(y_sq);
    end

    assign filt = y_reg;
    assign sq   = sq_reg;
endmodule

### rtl/imb_div.sv
module imb_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [imb_pkg::DIV_NW-1:0]  num,
    input  logic [imb_pkg::DIV_DW-1:0]  den,
    output logic                        busy,
    output logic                        done,
    output logic [imb_pkg::DIV_QW-1:0]  quot
);
    import imb_pkg::*;

    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_QW-1:0] low_reg, low_next;
    logic [DIV_QW-1:0] quot_reg, quot_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   diff;
    logic              ge;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        shifted   = {rem_reg, low_reg[DIV_QW-1]};
        diff      = shifted - {1'b0, den_reg};
        ge        = shifted >= {1'b0, den_reg};
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = DIV_DW'(num[DIV_NW-1:DIV_QW]);
            low_next  = num[DIV_QW-1:0];
            quot_next = '0;
            cnt_next  = 5'(DIV_QW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
            low_next  = {low_reg[DIV_QW-2:0], 1'b0};
            quot_next = {quot_reg[DIV_QW-2:0], ge};
            cnt_next  = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
        end
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;
endmodule

### rtl/imb_sqrt.sv
module imb_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] rad,
    output logic        busy,
    output logic        done,
    output logic [15:0] root
);
    import imb_pkg::*;

    logic [16:0] rem_reg, rem_next;
    logic [15:0] root_reg, root_next;
    logic [31:0] rad_reg, rad_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [18:0] r2;
    logic [18:0] trial;
    logic        ge;

    // one root bit per cycle, two radicand bits brought down
    always_comb
    begin
        r2        = {rem_reg, rad_reg[31:30]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = r2 >= trial;
        rem_next  = rem_reg;
        root_next = root_reg;
        rad_next  = rad_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            root_next = '0;
            rad_next  = rad;
            cnt_next  = 4'd15;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? 17'(r2 - trial) : r2[16:0];
            root_next = {root_reg[14:0], ge};
            rad_next  = {rad_reg[29:0], 2'b00};
            cnt_next  = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;
endmodule

### dv/tb_imu_motion_beta_scheduler.sv
module tb_imu_motion_beta_scheduler;
    timeunit 1ns;
    timeprecision 1ps;
    import imb_pkg::*;

    // predicts filter outputs, gain, flags and cadence for each sample
    class motion_scoreboard;
        logic signed [15:0] bias[3];
        logic [19:0] still_hold;
        logic [19:0] settle_time;
        logic [15:0] g_soft;
        logic [15:0] g_dyn;
        logic [15:0] g_settle;
        bit seeded;
        longint filt[6];
        longint unsigned still_t;
        longint unsigned settle_t;
        bit rotating;
        longint rate;
        out_item_t expected_q[$];
        int n_fail;
        int n_checked;
        int n_noted;

        function new();
            bias = '{16'sd0, 16'sd0, 16'sd0};
            still_hold = 20'd350000;
            settle_time = 20'd600000;
            g_soft = 16'd1311;
            g_dyn = 16'd3932;
            g_settle = 16'd19661;
            seeded = 0;
            foreach (filt[i]) filt[i] = 0;
            still_t = 0;
            settle_t = 0;
            rotating = 0;
            rate = 7680;
            n_fail = 0;
            n_checked = 0;
            n_noted = 0;
        endfunction

        function void write_reg(logic [IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] v);
            case (idx)
                REG_BIAS_X: bias[0] = v[15:0];
                REG_BIAS_Y: bias[1] = v[15:0];
                REG_BIAS_Z: bias[2] = v[15:0];
                REG_STILL:  still_hold = v;
                REG_SETTLE: settle_time = v;
                REG_G_SOFT: g_soft = v[15:0];
                REG_G_DYN:  g_dyn = v[15:0];
                REG_G_SETL: g_settle = v[15:0];
                default: ;
            endcase
        endfunction

        // product scaled by 2^-16, rounded half away from zero
        static function longint scale_round(longint a, longint d);
            longint p;
            longint m;
            p = a * d;
            m = (p < 0) ? -p : p;
            m = (m + 32768) >>> 16;
            return (p < 0) ? -m : m;
        endfunction

        static function longint unsigned floor_sqrt(longint unsigned n);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 20; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= n)
                    r = t;
            end
            return r;
        endfunction

        static function longint unsigned metric_of(longint unsigned v);
            longint unsigned m;
            m = (v * 160) / 3;
            return (m > 65536) ? 65536 : m;
        endfunction

        function void note_sample(in_item_t it);
            longint unsigned dt;
            longint unsigned x;
            longint unsigned den;
            longint unsigned coef;
            longint unsigned sq;
            longint unsigned amag;
            longint unsigned gnorm;
            longint unsigned err;
            longint unsigned metric;
            longint unsigned desired;
            longint unsigned period;
            longint s[6];
            longint g;
            logic [15:0] gain;
            bit still;
            out_item_t o;

            dt = it.elapsed_us;
            if (dt < 500) dt = 500;
            if (dt > 200000) dt = 200000;
            s[0] = it.accel_x;
            s[1] = it.accel_y;
            s[2] = it.accel_z;
            s[3] = it.gyro_x;
            s[4] = it.gyro_y;
            s[5] = it.gyro_z;
            // bias removal saturates to the sample range
            for (int i = 0; i < 3; i++)
            begin
                g = s[3+i] - longint'(bias[i]);
                if (g > 32767) g = 32767;
                if (g < -32768) g = -32768;
                s[3+i] = g;
            end

            // dt-dependent low-pass coefficient
            x = 64'd4941298 * dt;
            den = 64'd65536000000 + x;
            coef = (x * 65536 + den / 2) / den;
            for (int i = 0; i < 6; i++)
            begin
                if (!seeded)
                    filt[i] = s[i];
                else
                    filt[i] = filt[i] + scale_round(longint'(coef), s[i] - filt[i]);
            end
            seeded = 1;

            sq = 0;
            for (int i = 0; i < 3; i++) sq += longint'(filt[i] * filt[i]);
            amag = floor_sqrt(sq);
            sq = 0;
            for (int i = 3; i < 6; i++) sq += longint'(filt[i] * filt[i]);
            gnorm = floor_sqrt(sq);
            err = (amag >= 4096) ? amag - 4096 : 4096 - amag;

            // still timer
            if (err <= 204 && gnorm <= 81)
            begin
                still_t = still_t + dt;
                if (still_t > 1048575) still_t = 1048575;
            end
            else
                still_t = 0;
            still = (still_t >= still_hold);

            // rotation and settle window
            if (gnorm >= 359)
            begin
                rotating = 1;
                settle_t = 0;
            end
            else if (rotating)
            begin
                settle_t = settle_t + dt;
                if (settle_t > 1048575) settle_t = 1048575;
                if (settle_t >= settle_time)
                begin
                    rotating = 0;
                    settle_t = 0;
                end
            end

            if (err >= 1025) gain = 16'd0;
            else if (err >= 615) gain = g_soft;
            else if (still || rotating) gain = g_settle;
            else gain = g_dyn;

            // cadence
            metric = metric_of(gnorm);
            if (metric_of(err) > metric) metric = metric_of(err);
            desired = 6400 + ((64'd8960 * metric + 32768) >> 16);
            rate = rate + scale_round(11796, longint'(desired) - rate);
            if (rate < 6400) rate = 6400;
            if (rate > 15360) rate = 15360;
            period = 64'd256000000 / longint'(rate);
            if (period < 2000) period = 2000;
            if (period > 200000) period = 200000;

            o.filt_accel_x = sample_t'(filt[0]);
            o.filt_accel_y = sample_t'(filt[1]);
            o.filt_accel_z = sample_t'(filt[2]);
            o.filt_gyro_x = sample_t'(filt[3]);
            o.filt_gyro_y = sample_t'(filt[4]);
            o.filt_gyro_z = sample_t'(filt[5]);
            o.fusion_gain = gain;
            o.still_det = still;
            o.settle_win = rotating;
            o.target_rate_hz = rate[13:0];
            o.next_period_us = period[17:0];
            expected_q.push_back(o);
            n_noted++;
        endfunction

        function void cmp(string f, longint e, longint a);
            if (e != a)
            begin
                $error("%s: expected %0d, got %0d", f, e, a);
                n_fail++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (expected_q.size() == 0)
            begin
                $error("result item with no sample pending");
                n_fail++;
                return;
            end
            e = expected_q.pop_front();
            n_checked++;
            cmp("filt_accel_x", e.filt_accel_x, got.filt_accel_x);
            cmp("filt_accel_y", e.filt_accel_y, got.filt_accel_y);
            cmp("filt_accel_z", e.filt_accel_z, got.filt_accel_z);
            cmp("filt_gyro_x", e.filt_gyro_x, got.filt_gyro_x);
            cmp("filt_gyro_y", e.filt_gyro_y, got.filt_gyro_y);
            cmp("filt_gyro_z", e.filt_gyro_z, got.filt_gyro_z);
            cmp("fusion_gain", e.fusion_gain, got.fusion_gain);
            cmp("still_det", e.still_det, got.still_det);
            cmp("settle_win", e.settle_win, got.settle_win);
            cmp("target_rate_hz", e.target_rate_hz, got.target_rate_hz);
            cmp("next_period_us", e.next_period_us, got.next_period_us);
        endfunction
    endclass

    typedef enum int {M_STILL, M_ROTATE, M_SOFT, M_NOISE} motion_mode_e;

    localparam int CYCLE_LIMIT = 1000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;
    int cycles;
    int n_settings;
    bit quiet_src;
    bit quiet_snk;
    bit held_off;

    imb_in_if in_if();
    imb_out_if out_if();
    motion_scoreboard sb;

    imu_motion_beta_scheduler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_imu_motion_beta_scheduler: FAIL");
            $finish;
        end
    end

    // accepted samples and results
    always @(posedge clk)
    begin
        if (rst_n && in_if.valid && in_if.ready)
            sb.note_sample(in_if.data);
        if (rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.data);
    end

    // receiver stalls, with one long hold-off while the sender keeps offering
    initial
    begin : receiver
        int hold;
        int r;
        hold = 0;
        held_off = 0;
        out_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && sb.n_checked >= 300)
            begin
                held_off = 1;
                hold = 600;
            end
            if ($urandom_range(0, 299) == 0) quiet_snk = ~quiet_snk;
            if (hold > 0)
            begin
                out_if.ready <= 1'b0;
                hold--;
            end
            else if (quiet_snk)
                out_if.ready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    out_if.ready <= 1'b1;
                else
                begin
                    out_if.ready <= 1'b0;
                    hold = (r < 96) ? $urandom_range(0, 3) : $urandom_range(15, 80);
                end
            end
        end
    end

    function automatic sample_t clamp16(int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return sample_t'(v);
    endfunction

    function automatic int sgn_rand(int lo, int hi);
        int m;
        m = $urandom_range(hi, lo);
        return $urandom_range(0, 1) ? m : -m;
    endfunction

    function automatic in_item_t make_sample(motion_mode_e mode);
        in_item_t it;
        int r;
        int ax;
        r = $urandom_range(0, 9);
        if (r < 8) it.elapsed_us = 18'($urandom_range(45000, 15000));
        else if (r < 9) it.elapsed_us = 18'($urandom_range(600, 0));
        else it.elapsed_us = 18'($urandom());
        it.accel_x = clamp16(sgn_rand(0, 120));
        it.accel_y = clamp16(sgn_rand(0, 120));
        it.accel_z = clamp16(sgn_rand(3990, 4200));
        it.gyro_x = clamp16(int'(sb.bias[0]) + sgn_rand(0, 40));
        it.gyro_y = clamp16(int'(sb.bias[1]) + sgn_rand(0, 40));
        it.gyro_z = clamp16(int'(sb.bias[2]) + sgn_rand(0, 40));
        case (mode)
            M_ROTATE:
            begin
                ax = $urandom_range(0, 2);
                if (ax == 0) it.gyro_x = clamp16(int'(sb.bias[0]) + sgn_rand(400, 9000));
                if (ax == 1) it.gyro_y = clamp16(int'(sb.bias[1]) + sgn_rand(400, 9000));
                if (ax == 2) it.gyro_z = clamp16(int'(sb.bias[2]) + sgn_rand(400, 9000));
            end
            M_SOFT:
                it.accel_z = clamp16(sgn_rand(3000, 5200));
            M_NOISE:
            begin
                it.accel_x = sample_t'($urandom());
                it.accel_y = sample_t'($urandom());
                it.accel_z = sample_t'($urandom());
                it.gyro_x = sample_t'($urandom());
                it.gyro_y = sample_t'($urandom());
                it.gyro_z = sample_t'($urandom());
            end
            default: ;
        endcase
        return it;
    endfunction

    // offer one sample and hold it until accepted, then maybe idle
    task automatic send_sample(in_item_t it);
        int r;
        int gap;
        in_if.valid <= 1'b1;
        in_if.data <= it;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        r = $urandom_range(0, 99);
        if (quiet_src || r < 50) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_fields(int dt, int ax, int ay, int az, int gx, int gy, int gz);
        in_item_t it;
        it.elapsed_us = 18'(dt);
        it.accel_x = sample_t'(ax);
        it.accel_y = sample_t'(ay);
        it.accel_z = sample_t'(az);
        it.gyro_x = sample_t'(gx);
        it.gyro_y = sample_t'(gy);
        it.gyro_z = sample_t'(gz);
        send_sample(it);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // one register write; the caller lowers the write enable after the last one
    task automatic write_reg(logic [IDX_WIDTH-1:0] idx, int unsigned v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[CFG_WIDTH-1:0];
        @(posedge clk);
        sb.write_reg(idx, v[CFG_WIDTH-1:0]);
    endtask

    task automatic write_all(int unsigned bx, int unsigned by, int unsigned bz,
                             int unsigned hold, int unsigned settle,
                             int unsigned gs, int unsigned gd, int unsigned gst);
        write_reg(REG_BIAS_X, bx);
        write_reg(REG_BIAS_Y, by);
        write_reg(REG_BIAS_Z, bz);
        write_reg(REG_STILL, hold);
        write_reg(REG_SETTLE, settle);
        write_reg(REG_G_SOFT, gs);
        write_reg(REG_G_DYN, gd);
        write_reg(REG_G_SETL, gst);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // bursts of one motion kind with random content
    task automatic run_random(int n);
        motion_mode_e mode;
        int left;
        int r;
        left = 0;
        mode = M_STILL;
        for (int k = 0; k < n; k++)
        begin
            if (left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 40) mode = M_STILL;
                else if (r < 65) mode = M_ROTATE;
                else if (r < 80) mode = M_SOFT;
                else mode = M_NOISE;
                left = $urandom_range(3, 20);
                if ($urandom_range(0, 4) == 0) quiet_src = ~quiet_src;
            end
            send_sample(make_sample(mode));
            left--;
        end
    endtask

    initial
    begin : stimulus
        sb = new();
        cycles = 0;
        n_settings = 1;
        quiet_src = 0;
        quiet_snk = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_if.valid <= 1'b0;
        in_if.data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: seeding, elapsed clamps, field extremes, still, rotation, settle
        send_fields(0, 0, 0, 4096, 0, 0, 0);
        send_fields(499, 0, 0, 4096, 0, 0, 0);
        send_fields(500, 0, 0, 4096, 0, 0, 0);
        send_fields(200000, 0, 0, 4096, 0, 0, 0);
        send_fields(200001, 0, 0, 4096, 0, 0, 0);
        send_fields(262143, 0, 0, 4096, 0, 0, 0);
        send_fields(200000, 0, 0, 4096, 0, 0, 0);
        send_fields(20000, 0, 0, 4700, 0, 0, 0);
        send_fields(20000, 0, 0, 5500, 0, 0, 0);
        send_fields(262143, 32767, 32767, 32767, 32767, 32767, 32767);
        send_fields(262143, -32768, -32768, -32768, -32768, -32768, -32768);
        send_fields(1000, 0, 0, 4096, 0, 0, 0);
        send_fields(200000, 0, 0, 4096, 0, 0, 0);
        send_fields(200000, 0, 0, 4096, 0, 0, 0);
        send_fields(20000, 0, 0, 4096, 2000, 0, 0);
        send_fields(200000, 0, 0, 4096, 0, 0, 0);
        send_fields(200000, 0, 0, 4096, 0, 0, 0);
        send_fields(200000, 0, 0, 4096, 0, 0, 0);
        send_fields(200000, 0, 0, 4096, 0, 0, 0);
        wait_idle();

        // bias extremes drive the corrected gyro into saturation
        write_all(16'h7fff, 16'h8000, 100, 0, 0, 0, 65535, 1);
        send_fields(30000, 0, 0, 4096, -32768, 32767, 0);
        send_fields(30000, 0, 0, 4096, 32767, -32768, 100);
        send_fields(30000, 0, 0, 4096, -32768, 32767, 100);
        run_random(200);
        wait_idle();

        // longest timers and swapped gain extremes
        write_all(16'hffd0, 25, 16'hfff6, 1048575, 1048575, 65535, 0, 65535);
        for (int k = 0; k < 7; k++) send_fields(200000, 0, 0, 4096, -48, 25, -10);
        run_random(200);
        wait_idle();

        // back to reset values
        write_all(0, 0, 0, 350000, 600000, 1311, 3932, 19661);
        run_random(230);
        wait_idle();

        // random settings
        write_all(sgn_rand(0, 300) & 16'hffff, sgn_rand(0, 300) & 16'hffff,
                  sgn_rand(0, 300) & 16'hffff, $urandom_range(0, 600000),
                  $urandom_range(0, 1000000), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
        run_random(230);

        wait_idle();
        repeat (100) @(posedge clk);
        $display("run covered %0d samples, %0d results checked, %0d register settings",
                 sb.n_noted, sb.n_checked, n_settings);
        $display("still, rotation, accel error and noise bursts under random stalls");
        if (sb.n_fail == 0 && sb.expected_q.size() == 0)
            $display("tb_imu_motion_beta_scheduler: PASS");
        else
            $display("tb_imu_motion_beta_scheduler: FAIL");
        $finish;
    end

endmodule

### imu_motion_beta_scheduler.f
rtl/imb_pkg.sv
rtl/imb_in_if.sv
rtl/imb_out_if.sv
rtl/imb_lane.sv
rtl/imb_div.sv
rtl/imb_sqrt.sv
rtl/imu_motion_beta_scheduler.sv
dv/tb_imu_motion_beta_scheduler.sv
